@@ rtl/bdp_pkg.sv @@
// Package for the power-of-two box downsampler.
// Holds the item types, register indexes, limits and reset values.
// No dependencies.
package bdp_pkg;

   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int ACC_DEPTH_DEF  = 2048;
   localparam int MAX_FACTOR_DEF = 4;
   localparam int HEIGHT_LIMIT   = 4096;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] REG_REDUCE_FACTOR = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA_PRESENT = 2'd3;

   localparam int RST_FACTOR = 1;
   localparam int RST_WIDTH  = 640;
   localparam int RST_HEIGHT = 480;

   typedef struct packed {
      logic [7:0] in_red;
      logic [7:0] in_green;
      logic [7:0] in_blue;
      logic [7:0] in_alpha;
   } req_type;

   typedef struct packed {
      logic [7:0] out_red;
      logic [7:0] out_green;
      logic [7:0] out_blue;
      logic [7:0] out_alpha;
      logic       end_of_row;
      logic       end_of_frame;
   } rsp_type;

endpackage

@@ rtl/bdp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the column accumulator of the downsampler. No dependencies.
module bdp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/box_downsample_pow2.sv @@
// Top level of the power-of-two box downsampler: counters, block sums, output queue.
// Depends on bdp_pkg and bdp_ram.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   request | req_valid, req_stall, req_data          | in
//   result  | rsp_valid, rsp_stall, rsp_data          | out
//   csr     | csr_valid, csr_ready, csr_index, csr_wdata | in
//
// One input item per cycle while req_stall is low. A block result leaves the
// accumulator read stage in the cycle after its last pixel is taken and then waits
// in a four-entry queue. The accumulator RAM does one read and one write a cycle.
// req_stall rises once three queue entries are held or about to be filled. Reset is
// synchronous; accumulator contents are not cleared, since the first row of a band
// writes first.
module box_downsample_pow2 #(
   parameter int MAX_WIDTH  = bdp_pkg::MAX_WIDTH_DEF,
   parameter int ACC_DEPTH  = bdp_pkg::ACC_DEPTH_DEF,
   parameter int MAX_FACTOR = bdp_pkg::MAX_FACTOR_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bdp_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bdp_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bdp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [bdp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import bdp_pkg::*;

   localparam int FW  = $clog2(MAX_FACTOR + 1);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int CWB = $clog2(MAX_WIDTH);
   localparam int CW  = (CWB > MAX_FACTOR) ? CWB : MAX_FACTOR;
   localparam int HW  = $clog2(HEIGHT_LIMIT + 1);
   localparam int RW  = $clog2(HEIGHT_LIMIT);
   localparam int XW  = ((CW > WW) ? CW : WW) + 1;
   localparam int YW  = ((RW > HW) ? RW : HW) + 1;
   localparam int AW  = (ACC_DEPTH > 1) ? $clog2(ACC_DEPTH) : 1;
   localparam int SW  = FW + 1;
   localparam int RST_F = (RST_FACTOR > MAX_FACTOR) ? MAX_FACTOR : RST_FACTOR;
   localparam int RST_W = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;

   // configuration, held already clamped
   logic [FW-1:0] factor_ff;
   logic [WW-1:0] width_ff;
   logic [HW-1:0] height_ff;
   logic          alpha_ff;
   logic          csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff <= FW'(RST_F);
         width_ff  <= WW'(RST_W);
         height_ff <= HW'(RST_HEIGHT);
         alpha_ff  <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            REG_REDUCE_FACTOR: begin
               if (32'(csr_wdata[2:0]) > 32'(MAX_FACTOR)) begin
                  factor_ff <= FW'(MAX_FACTOR);
               end else begin
                  factor_ff <= FW'(csr_wdata[2:0]);
               end
            end
            REG_IMAGE_WIDTH: begin
               if (csr_wdata == '0) begin
                  width_ff <= WW'(1);
               end else if (32'(csr_wdata) > 32'(MAX_WIDTH)) begin
                  width_ff <= WW'(MAX_WIDTH);
               end else begin
                  width_ff <= WW'(csr_wdata);
               end
            end
            REG_IMAGE_HEIGHT: begin
               if (csr_wdata == '0) begin
                  height_ff <= HW'(1);
               end else if (32'(csr_wdata) > 32'(HEIGHT_LIMIT)) begin
                  height_ff <= HW'(HEIGHT_LIMIT);
               end else begin
                  height_ff <= HW'(csr_wdata);
               end
            end
            REG_ALPHA_PRESENT: alpha_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // stage 0: counters and horizontal sum
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [31:0]   hsum_ff, hsum_in;
   logic          accept;
   logic [CW-1:0] col_sub, bx;
   logic [RW-1:0] row_sub, by;
   logic [WW-1:0] outw;
   logic [HW-1:0] outh;
   logic [SW-1:0] sh;
   logic [31:0]   packed_px;
   logic          in_blk, blk_end, row_first, row_last, eor, eof, acc_ok;
   logic [XW-1:0] col_inc;
   logic [YW-1:0] row_inc;

   assign accept  = req_valid && !req_stall;
   assign col_sub = ~({CW{1'b1}} << factor_ff);
   assign row_sub = ~({RW{1'b1}} << factor_ff);
   assign bx      = col_ff >> factor_ff;
   assign by      = row_ff >> factor_ff;
   assign outw    = width_ff >> factor_ff;
   assign outh    = height_ff >> factor_ff;
   assign sh      = SW'(factor_ff) << 1;

   assign packed_px[7:0]   = req_data.in_red >> sh;
   assign packed_px[15:8]  = req_data.in_green >> sh;
   assign packed_px[23:16] = req_data.in_blue >> sh;
   assign packed_px[31:24] = alpha_ff ? (req_data.in_alpha >> sh) : 8'd0;

   assign in_blk    = (XW'(bx) < XW'(outw)) && (YW'(by) < YW'(outh));
   assign blk_end   = (col_ff & col_sub) == col_sub;
   assign row_first = (row_ff & row_sub) == '0;
   assign row_last  = (row_ff & row_sub) == row_sub;
   assign eor       = XW'(bx) == (XW'(outw) - XW'(1));
   assign eof       = eor && (YW'(by) == (YW'(outh) - YW'(1)));
   assign acc_ok    = 32'(bx) < 32'(ACC_DEPTH);
   assign col_inc   = XW'(col_ff) + XW'(1);
   assign row_inc   = YW'(row_ff) + YW'(1);

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      hsum_in = hsum_ff;
      if (accept) begin
         if (in_blk) begin
            hsum_in = ((col_ff & col_sub) == '0) ? packed_px : hsum_ff + packed_px;
         end
         if (col_inc >= XW'(width_ff)) begin
            col_in = '0;
            row_in = (row_inc >= YW'(height_ff)) ? '0 : RW'(row_inc);
         end else begin
            col_in = CW'(col_inc);
         end
      end
      if (csr_write) begin
         col_in  = '0;
         row_in  = '0;
         hsum_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff  <= '0;
         row_ff  <= '0;
         hsum_ff <= '0;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         hsum_ff <= hsum_in;
      end
   end

   // stage 1: accumulator read-modify-write
   logic          s1_valid_ff;
   logic          s1_first_ff, s1_last_ff, s1_ok_ff, s1_eor_ff, s1_eof_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [31:0]   s1_hsum_ff;
   logic [31:0]   ram_rd;
   logic [31:0]   acc;
   logic          s1_emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept && in_blk && blk_end;
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= row_first;
      s1_last_ff  <= row_last;
      s1_ok_ff    <= acc_ok;
      s1_eor_ff   <= eor;
      s1_eof_ff   <= eof;
      s1_addr_ff  <= AW'(bx);
      s1_hsum_ff  <= hsum_in;
   end

   assign acc     = s1_first_ff ? s1_hsum_ff
                                : (s1_ok_ff ? ram_rd : 32'd0) + s1_hsum_ff;
   assign s1_emit = s1_valid_ff && s1_last_ff;

   bdp_ram #(
      .WIDTH (32),
      .DEPTH (ACC_DEPTH)
   ) u_acc_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff && !s1_last_ff && s1_ok_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (acc),
      .rd_addr (AW'(bx)),
      .rd_data (ram_rd)
   );

   // output queue
   rsp_type    q_mem_ff [4];
   logic [1:0] q_wr_ff, q_rd_ff;
   logic [2:0] q_cnt_ff;
   logic       q_pop;
   rsp_type    q_item;

   assign rsp_valid = q_cnt_ff != 3'd0;
   assign rsp_data  = q_mem_ff[q_rd_ff];
   assign q_pop     = rsp_valid && !rsp_stall;
   assign req_stall = (q_cnt_ff + 3'(s1_emit)) > 3'd2;

   assign q_item.out_red      = acc[7:0];
   assign q_item.out_green    = acc[15:8];
   assign q_item.out_blue     = acc[23:16];
   assign q_item.out_alpha    = acc[31:24];
   assign q_item.end_of_row   = s1_eor_ff;
   assign q_item.end_of_frame = s1_eof_ff;

   always_ff @(posedge clock) begin
      if (s1_emit) begin
         q_mem_ff[q_wr_ff] <= q_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wr_ff  <= '0;
         q_rd_ff  <= '0;
         q_cnt_ff <= '0;
      end else begin
         q_wr_ff  <= q_wr_ff + 2'(s1_emit);
         q_rd_ff  <= q_rd_ff + 2'(q_pop);
         q_cnt_ff <= q_cnt_ff + 3'(s1_emit) - 3'(q_pop);
      end
   end

endmodule
